// ===== hw/rtl/kst_pkg.sv =====
// Shared types, operation codes and the set-1 translation table for the
// scan code key state tracker. No dependencies.
package kst_pkg;

    typedef enum logic [2:0] {
        MODE_SCAN     = 3'd0,
        MODE_READ     = 3'd1,
        MODE_CONSUME  = 3'd2,
        MODE_CLEAR    = 3'd3,
        MODE_CLR_LAST = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] scan_code;
        logic [7:0] key;
    } t_in_item;

    typedef struct packed {
        logic [7:0] last_raw;
        logic [7:0] recent_key;
        logic [7:0] key_state;
        logic       key_down;
        logic       key_edge;
    } t_out_item;

    // Write port of the state store.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_wr_req;

    localparam int unsigned XLAT_DEPTH = 84;

    localparam logic [7:0] STATE_EDGE     = 8'h01;
    localparam logic [7:0] STATE_STEP     = 8'h02;
    localparam logic [7:0] STATE_LIMIT    = 8'hFD;
    localparam logic [7:0] EDGE_CLR_MASK  = 8'hFE;

    localparam logic [7:0] XLAT_ROM [0:XLAT_DEPTH-1] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h0D, 8'h82, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
        8'h4A, 8'h4B, 8'h4C, 8'h3B, 8'h27, 8'h60, 8'h83, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h84, 8'h2A, 8'h85, 8'h20, 8'h86, 8'hC9,
        8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'h87, 8'h88, 8'h9D,
        8'h9E, 8'h9F, 8'h2D, 8'h9A, 8'h9B, 8'h9C, 8'h2B, 8'h97, 8'h98, 8'h99, 8'h96, 8'h89
    };

    // Codes beyond the table translate to key 0.
    function automatic logic [7:0] kst_xlat(input logic [6:0] idx);
        logic [7:0] v;
        v = 8'h00;
        if (idx < 7'(XLAT_DEPTH)) begin
            v = XLAT_ROM[idx];
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/kst_store.sv =====
// Key state store: one byte per key slot in a synchronous RAM, with
// per-slot valid bits cleared by reset. Depends on kst_pkg.
module kst_store
    import kst_pkg::*;
#(
    parameter int unsigned KEY_SLOTS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en,
    input  logic [7:0] i_rd_addr,
    output logic [7:0] o_rd_data,
    input  t_wr_req    i_wr
);

    localparam int unsigned AW = $clog2(KEY_SLOTS);

    logic [7:0]           r_mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] r_vld;
    logic [7:0]           r_rdata;
    logic                 r_rvld;
    logic                 r_hit;
    logic [7:0]           r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr[AW-1:0]] <= 1'b1;
        end
    end

    // A read in the same cycle as a write to that slot sees the old byte,
    // so the written byte is carried along and takes priority.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rvld <= r_vld[i_rd_addr[AW-1:0]];
            r_hit  <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_fwd  <= i_wr.data;
        end
    end

    assign o_rd_data = r_hit ? r_fwd : (r_rvld ? r_rdata : 8'h00);

endmodule

// ===== hw/rtl/kst_update.sv =====
// Modify step of the read-modify-write: new state byte, write request and
// last pressed key for one operation. Depends on kst_pkg.
module kst_update
    import kst_pkg::*;
(
    input  logic [2:0] i_mode,
    input  logic [7:0] i_raw,
    input  logic [7:0] i_addr,
    input  logic       i_in_range,
    input  logic       i_commit,
    input  logic [7:0] i_rd_data,
    input  logic [7:0] i_recent_key,
    output t_wr_req    o_wr,
    output logic [7:0] o_state,
    output logic [7:0] o_recent_key
);

    logic [7:0] cur;
    logic [7:0] pressed;
    logic [7:0] nxt;
    logic       wr;

    always_comb begin
        cur          = i_in_range ? i_rd_data : 8'h00;
        pressed      = (cur == 8'h00) ? STATE_EDGE : cur;
        nxt          = cur;
        wr           = 1'b0;
        o_recent_key = i_recent_key;
        case (i_mode)
            MODE_SCAN: begin
                wr = 1'b1;
                if (i_raw[7]) begin
                    nxt          = 8'h00;
                    o_recent_key = 8'h00;
                end else begin
                    if (cur == 8'h00) begin
                        o_recent_key = i_addr;
                    end
                    nxt = (pressed <= STATE_LIMIT) ? pressed + STATE_STEP : pressed;
                end
            end
            MODE_CONSUME: begin
                wr  = 1'b1;
                nxt = cur & EDGE_CLR_MASK;
            end
            MODE_CLEAR: begin
                wr  = 1'b1;
                nxt = 8'h00;
            end
            MODE_CLR_LAST: begin
                o_recent_key = 8'h00;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    assign o_wr.en   = wr && i_in_range && i_commit;
    assign o_wr.addr = i_addr;
    assign o_wr.data = nxt;
    // Keys outside the store have no byte and report zero.
    assign o_state   = i_in_range ? nxt : 8'h00;

endmodule

// ===== hw/rtl/scan_code_key_state_tracker.sv =====
// Scan code key state tracker: translates set-1 scan codes and keeps one
// state byte per key. An accepted item is registered in the read stage and
// then in the output register; throughput is one item per cycle while the
// output does not stall, set by the single RAM read port, with same-slot
// writes forwarded to the next read. Synchronous reset clears the last codes
// and all slot valid bits; the block accepts items right after reset.
module scan_code_key_state_tracker
    import kst_pkg::*;
#(
    parameter int unsigned TRANSLATION_ENTRIES = 84,
    parameter int unsigned KEY_SLOTS           = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [7:0] XLAT_LIM  = 8'(TRANSLATION_ENTRIES);
    localparam logic [8:0] SLOT_LIM  = 9'(KEY_SLOTS);

    logic       in_xfer;
    logic       out_free;
    logic       adv;
    logic [7:0] xkey;
    logic [7:0] addr;

    logic       r_s1_vld;
    logic [2:0] r_s1_mode;
    logic [7:0] r_s1_raw;
    logic [7:0] r_s1_addr;
    logic       r_s1_inr;
    logic [7:0] r_last_raw;
    logic [7:0] r_recent_key;
    logic       r_out_vld;
    t_out_item  r_out;

    logic [7:0] n_last_raw;
    logic [7:0] n_recent_key;
    logic [7:0] rd_data;
    logic [7:0] state;
    t_wr_req    wr;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_s1_vld && out_free;
    assign o_in_stall = r_s1_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_comb begin
        xkey = 8'h00;
        if ({1'b0, i_in_item.scan_code[6:0]} < XLAT_LIM) begin
            xkey = kst_xlat(i_in_item.scan_code[6:0]);
        end
        addr = (i_in_item.mode == MODE_SCAN) ? xkey : i_in_item.key;
    end

    kst_store #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    kst_update u_update (
        .i_mode       (r_s1_mode),
        .i_raw        (r_s1_raw),
        .i_addr       (r_s1_addr),
        .i_in_range   (r_s1_inr),
        .i_commit     (adv),
        .i_rd_data    (rd_data),
        .i_recent_key (r_recent_key),
        .o_wr         (wr),
        .o_state      (state),
        .o_recent_key (n_recent_key)
    );

    assign n_last_raw = (r_s1_mode == MODE_SCAN) ? r_s1_raw : r_last_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_mode <= i_in_item.mode;
            r_s1_raw  <= i_in_item.scan_code;
            r_s1_addr <= addr;
            r_s1_inr  <= {1'b0, addr} < SLOT_LIM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw   <= 8'h00;
            r_recent_key <= 8'h00;
            r_out_vld    <= 1'b0;
        end else if (adv) begin
            r_last_raw   <= n_last_raw;
            r_recent_key <= n_recent_key;
            r_out_vld    <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.last_raw   <= n_last_raw;
            r_out.recent_key <= n_recent_key;
            r_out.key_state  <= state;
            r_out.key_down   <= (state != 8'h00);
            r_out.key_edge   <= state[0];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
